@@ hw/rtl/flsm_pkg.sv @@
package flsm_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned OpW     = 3;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Time limits are configured in seconds and compared in milliseconds.
  localparam int unsigned MsPerS = 1000;
  localparam int unsigned LimitW = CfgW + $clog2(MsPerS);

  // Register reset values, in seconds or pulses.
  localparam logic [CfgW-1:0] StallTimeoutRst  = 16'd30;
  localparam logic [CfgW-1:0] LeakGraceRst     = 16'd5;
  localparam logic [CfgW-1:0] LeakRebaseRst    = 16'd3600;
  localparam logic [CfgW-1:0] LeakToleranceRst = 16'd5;

  // Fault codes.
  localparam logic [CodeW-1:0] FaultNone     = 4'd0;
  localparam logic [CodeW-1:0] FaultTopFloat = 4'd1;
  localparam logic [CodeW-1:0] FaultNoFlow   = 4'd4;
  localparam logic [CodeW-1:0] FaultLeak     = 4'd5;
  localparam logic [CodeW-1:0] FaultSensor   = 4'd6;
  localparam logic [CodeW-1:0] FaultMax      = 4'd9;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_STATE  = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_MANUAL = 3'd3,
    OP_NOTIFY = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STALL_TIMEOUT  = 2'd0,
    CFG_LEAK_GRACE     = 2'd1,
    CFG_LEAK_REBASE    = 2'd2,
    CFG_LEAK_TOLERANCE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [CountW-1:0] pulse_count;
    logic [CountW-1:0] now_ms;
    logic              tank_full;
    logic              tank_empty;
    logic              fill_active;
    logic              manual_allowed;
    logic [CodeW-1:0]  upstream_error;
    logic [CodeW-1:0]  notify_code;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] fault_code;
    logic             trip_raised;
    logic             cleared;
  } out_item_t;

  typedef struct packed {
    cfg_reg_e        index;
    logic [CfgW-1:0] data;
  } cfg_write_t;

  // Converts a limit in seconds into milliseconds.
  function automatic logic [LimitW-1:0] to_ms(input logic [CfgW-1:0] secs);
    logic [LimitW-1:0] scale;
    scale = LimitW'(MsPerS);
    return LimitW'(secs) * scale;
  endfunction

endpackage

@@ hw/rtl/flsm_if.sv @@
// Input item channel.
interface flsm_in_if;
  logic               valid;
  logic               ready;
  flsm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result item channel.
interface flsm_out_if;
  logic                valid;
  logic                ready;
  flsm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface flsm_cfg_if;
  logic                 valid;
  logic                 ready;
  flsm_pkg::cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/flow_leak_safety_monitor_unit.sv @@
// Channel   Dir  Modport  Payload
// in_i      in   sink     opcode, pulse_count, now_ms, floats, fill, manual, error codes
// out_o     out  source   fault_code, trip_raised, cleared
// cfg_i     in   sink     register index (2 bits), write data (16 bits)
//
// One item per cycle while results are taken: an item sits in the input register, where the
// checks and the state update run, and then waits in the result register.
// The result is offered from the result register once the item leaves the input register.
// Reset clears the fault latch and all monitor state and loads default limits.
// A stalled result holds the input register once it is occupied; at most two items wait.
// Configuration writes are always taken; time limits are stored in milliseconds.
module flow_leak_safety_monitor_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  flsm_in_if.sink           in_i,
  flsm_out_if.source        out_o,
  flsm_cfg_if.sink          cfg_i
);

  localparam int unsigned CountW = flsm_pkg::CountW;
  localparam int unsigned CodeW  = flsm_pkg::CodeW;
  localparam int unsigned LimitW = flsm_pkg::LimitW;
  localparam int unsigned CfgW   = flsm_pkg::CfgW;

  // Time limits, kept in milliseconds so the item path has no multiplier; the leak tolerance in pulses.
  logic [LimitW-1:0] stall_ms_q, grace_ms_q, rebase_ms_q;
  logic [CfgW-1:0]   tolerance_q;

  // Monitor state.
  logic [CodeW-1:0]  latched_fault_q, latched_fault_d;
  logic              clear_pending_q, clear_pending_d;
  logic [CountW-1:0] last_pulse_seen_q, last_pulse_seen_d;
  logic [CountW-1:0] last_pulse_time_q, last_pulse_time_d;
  logic [CountW-1:0] leak_baseline_q, leak_baseline_d;
  logic [CountW-1:0] leak_base_time_q, leak_base_time_d;
  logic              manual_override_q, manual_override_d;

  // Pipeline registers.
  logic                s1_valid_q;
  flsm_pkg::in_item_t  s1_q;
  logic                out_valid_q;
  flsm_pkg::out_item_t out_q, out_d;

  logic s1_advance;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_ms_q  <= flsm_pkg::to_ms(flsm_pkg::StallTimeoutRst);
      grace_ms_q  <= flsm_pkg::to_ms(flsm_pkg::LeakGraceRst);
      rebase_ms_q <= flsm_pkg::to_ms(flsm_pkg::LeakRebaseRst);
      tolerance_q <= flsm_pkg::LeakToleranceRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        flsm_pkg::CFG_STALL_TIMEOUT:  stall_ms_q  <= flsm_pkg::to_ms(cfg_i.data.data);
        flsm_pkg::CFG_LEAK_GRACE:     grace_ms_q  <= flsm_pkg::to_ms(cfg_i.data.data);
        flsm_pkg::CFG_LEAK_REBASE:    rebase_ms_q <= flsm_pkg::to_ms(cfg_i.data.data);
        flsm_pkg::CFG_LEAK_TOLERANCE: tolerance_q <= cfg_i.data.data;
      endcase
    end
  end

  // Checks and state update for the item in the input register.
  always_comb begin
    logic [CodeW-1:0]  upstream;
    logic [CountW-1:0] pulses, now, age;
    logic              trip, did_clear, run, done;

    pulses = s1_q.pulse_count;
    now    = s1_q.now_ms;
    upstream = (s1_q.upstream_error > flsm_pkg::FaultMax) ? flsm_pkg::FaultNone
                                                           : s1_q.upstream_error;
    trip      = 1'b0;
    did_clear = 1'b0;
    run       = 1'b0;
    done      = 1'b0;
    age       = '0;

    latched_fault_d   = latched_fault_q;
    clear_pending_d   = clear_pending_q;
    last_pulse_seen_d = last_pulse_seen_q;
    last_pulse_time_d = last_pulse_time_q;
    leak_baseline_d   = leak_baseline_q;
    leak_base_time_d  = leak_base_time_q;
    manual_override_d = manual_override_q;

    unique case (s1_q.opcode)
      flsm_pkg::OP_TICK: begin
        // A pending clear is performed first.
        if (clear_pending_q) begin
          clear_pending_d   = 1'b0;
          latched_fault_d   = flsm_pkg::FaultNone;
          last_pulse_seen_d = '0;
          last_pulse_time_d = '0;
          leak_baseline_d   = pulses;
          leak_base_time_d  = now;
          did_clear         = 1'b1;
        end
        run = (latched_fault_d == flsm_pkg::FaultNone) && (upstream == flsm_pkg::FaultNone);
      end
      flsm_pkg::OP_STATE: begin
        if (s1_q.fill_active) begin
          last_pulse_seen_d = pulses;
          last_pulse_time_d = now;
        end else begin
          leak_baseline_d  = pulses;
          leak_base_time_d = now;
        end
      end
      flsm_pkg::OP_CLEAR: begin
        clear_pending_d = 1'b1;
      end
      flsm_pkg::OP_MANUAL: begin
        manual_override_d = s1_q.manual_allowed;
        if (!s1_q.manual_allowed) begin
          leak_baseline_d  = pulses;
          leak_base_time_d = now;
        end
      end
      flsm_pkg::OP_NOTIFY: begin
        if (latched_fault_q == flsm_pkg::FaultNone && s1_q.notify_code != flsm_pkg::FaultNone
            && s1_q.notify_code <= flsm_pkg::FaultMax) begin
          latched_fault_d = s1_q.notify_code;
          trip            = 1'b1;
        end
      end
      default: begin
        // Unused opcodes leave the state alone.
      end
    endcase

    // Fault checks, in priority order; the latch is known to be empty here.
    if (run) begin
      if (s1_q.tank_full && s1_q.tank_empty) begin
        latched_fault_d = flsm_pkg::FaultSensor;
        trip            = 1'b1;
        done            = 1'b1;
      end else if (s1_q.tank_full) begin
        latched_fault_d = flsm_pkg::FaultTopFloat;
        trip            = 1'b1;
        done            = 1'b1;
      end else if (s1_q.fill_active) begin
        // Stall detection while the valve is open.
        if (pulses != last_pulse_seen_d) begin
          last_pulse_seen_d = pulses;
          last_pulse_time_d = now;
        end
        if ((now - last_pulse_time_d) > CountW'(stall_ms_q)) begin
          latched_fault_d = flsm_pkg::FaultNoFlow;
          trip            = 1'b1;
        end
        done = 1'b1;
      end
      // Leak detection while the valve is closed and no override is set.
      if (!done && !manual_override_q) begin
        age = now - leak_base_time_d;
        if (age < CountW'(grace_ms_q)) begin
          leak_baseline_d = pulses;
        end else if ((pulses - leak_baseline_d) > CountW'(tolerance_q)) begin
          latched_fault_d = flsm_pkg::FaultLeak;
          trip            = 1'b1;
        end else if (age > CountW'(rebase_ms_q)) begin
          leak_baseline_d  = pulses;
          leak_base_time_d = now;
        end
      end
    end

    out_d.fault_code  = (latched_fault_d != flsm_pkg::FaultNone) ? latched_fault_d : upstream;
    out_d.trip_raised = trip;
    out_d.cleared     = did_clear;
  end

  // Monitor state advances once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_fault_q   <= flsm_pkg::FaultNone;
      clear_pending_q   <= 1'b0;
      last_pulse_seen_q <= '0;
      last_pulse_time_q <= '0;
      leak_baseline_q   <= '0;
      leak_base_time_q  <= '0;
      manual_override_q <= 1'b0;
    end else if (s1_advance) begin
      latched_fault_q   <= latched_fault_d;
      clear_pending_q   <= clear_pending_d;
      last_pulse_seen_q <= last_pulse_seen_d;
      last_pulse_time_q <= last_pulse_time_d;
      leak_baseline_q   <= leak_baseline_d;
      leak_base_time_q  <= leak_base_time_d;
      manual_override_q <= manual_override_d;
    end
  end

  // Valid flags of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
    if (s1_advance) begin
      out_q <= out_d;
    end
  end

endmodule

@@ hw/rtl/flsm_checker.sv @@
module flsm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input flsm_pkg::out_item_t out_data_i
);

  // A stalled result stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or was dropped");

  // A trip always reports a fault code other than none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.trip_raised |-> out_data_i.fault_code != flsm_pkg::FaultNone)
    else $error("trip raised without a fault code");

  // Reported codes stay within the defined fault numbering.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.fault_code <= flsm_pkg::FaultMax)
    else $error("fault code out of range");

endmodule

bind flow_leak_safety_monitor_unit flsm_checker u_flsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned OpW    = flsm_pkg::OpW;
  localparam int unsigned CountW = flsm_pkg::CountW;
  localparam int unsigned CodeW  = flsm_pkg::CodeW;
  localparam int unsigned CfgW   = flsm_pkg::CfgW;

  // Opcodes outside the defined set; the block must leave its state alone.
  localparam logic [OpW-1:0] OpUnusedLo = 3'd5;
  localparam logic [OpW-1:0] OpUnusedHi = 3'd7;

  localparam int unsigned ItemsPerPhase  = 150;
  localparam int unsigned NumPhases      = 5;
  localparam int unsigned LongHoldCycles = 250;
  localparam int unsigned LongHoldAfter  = 400;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned TailCycles     = 8;

  typedef struct {
    flsm_pkg::in_item_t  item;
    bit                  typed;
    flsm_pkg::out_item_t status;
  } stim_row_t;

  logic clk;
  logic rst_n;

  flsm_in_if  in_bus ();
  flsm_out_if out_bus ();
  flsm_cfg_if cfg_bus ();

  flow_leak_safety_monitor_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor state mirrored from the block, reset values as after reset.
  logic [CodeW-1:0]  latched_code  = flsm_pkg::FaultNone;
  bit                clear_armed   = 1'b0;
  logic [CountW-1:0] pulse_mark    = '0;
  logic [CountW-1:0] pulse_mark_ms = '0;
  logic [CountW-1:0] leak_ref      = '0;
  logic [CountW-1:0] leak_ref_ms   = '0;
  bit                manual_on     = 1'b0;

  // Mirrored limit registers.
  logic [CfgW-1:0] stall_lim_s  = flsm_pkg::StallTimeoutRst;
  logic [CfgW-1:0] grace_lim_s  = flsm_pkg::LeakGraceRst;
  logic [CfgW-1:0] rebase_lim_s = flsm_pkg::LeakRebaseRst;
  logic [CfgW-1:0] leak_tol     = flsm_pkg::LeakToleranceRst;

  flsm_pkg::out_item_t status_due [$];
  stim_row_t           directed_rows [$];
  int unsigned         errors = 0;
  int unsigned         inputs_taken = 0;
  int unsigned         idle_cycles = 0;
  bit                  long_hold_done = 1'b0;

  // Status that travels with the item on the input channel when it is typed in.
  bit                  row_typed;
  flsm_pkg::out_item_t row_status;

  // Simulated plant used to build coherent random ticks.
  logic [CountW-1:0] plant_ms = '0;
  logic [CountW-1:0] plant_pulses = '0;
  bit                plant_filling = 1'b0;

  function automatic logic [31:0] secs_to_ms(input logic [CfgW-1:0] secs);
    return {16'd0, secs} * flsm_pkg::MsPerS;
  endfunction

  function automatic bit latch_code(input logic [CodeW-1:0] code);
    if (latched_code != flsm_pkg::FaultNone || code == flsm_pkg::FaultNone ||
        code > flsm_pkg::FaultMax) return 1'b0;
    latched_code = code;
    return 1'b1;
  endfunction

  // Float, stall and leak checks of a tick; returns whether a fault latched.
  function automatic bit run_safety_checks(input flsm_pkg::in_item_t it);
    logic [31:0] age;
    logic [31:0] rise;
    if (it.tank_full && it.tank_empty) return latch_code(flsm_pkg::FaultSensor);
    if (it.tank_full) return latch_code(flsm_pkg::FaultTopFloat);
    if (it.fill_active) begin
      if (it.pulse_count != pulse_mark) begin
        pulse_mark    = it.pulse_count;
        pulse_mark_ms = it.now_ms;
      end
      age = it.now_ms - pulse_mark_ms;
      if (age > secs_to_ms(stall_lim_s)) return latch_code(flsm_pkg::FaultNoFlow);
    end
    if (!it.fill_active && !manual_on) begin
      age = it.now_ms - leak_ref_ms;
      if (age < secs_to_ms(grace_lim_s)) begin
        leak_ref = it.pulse_count;
      end else begin
        rise = it.pulse_count - leak_ref;
        if (rise > {16'd0, leak_tol}) return latch_code(flsm_pkg::FaultLeak);
        if (age > secs_to_ms(rebase_lim_s)) begin
          leak_ref    = it.pulse_count;
          leak_ref_ms = it.now_ms;
        end
      end
    end
    return 1'b0;
  endfunction

  // Expected status for one item; updates the mirrored state.
  function automatic flsm_pkg::out_item_t predict_status(input flsm_pkg::in_item_t it);
    flsm_pkg::out_item_t res;
    logic [CodeW-1:0]    up;
    up = (it.upstream_error > flsm_pkg::FaultMax) ? flsm_pkg::FaultNone : it.upstream_error;
    res.trip_raised = 1'b0;
    res.cleared     = 1'b0;
    unique case (it.opcode)
      flsm_pkg::OP_TICK: begin
        if (clear_armed) begin
          clear_armed   = 1'b0;
          latched_code  = flsm_pkg::FaultNone;
          pulse_mark    = '0;
          pulse_mark_ms = '0;
          leak_ref      = it.pulse_count;
          leak_ref_ms   = it.now_ms;
          res.cleared   = 1'b1;
        end
        if (latched_code == flsm_pkg::FaultNone && up == flsm_pkg::FaultNone) begin
          res.trip_raised = run_safety_checks(it);
        end
      end
      flsm_pkg::OP_STATE: begin
        if (it.fill_active) begin
          pulse_mark    = it.pulse_count;
          pulse_mark_ms = it.now_ms;
        end else begin
          leak_ref    = it.pulse_count;
          leak_ref_ms = it.now_ms;
        end
      end
      flsm_pkg::OP_CLEAR: clear_armed = 1'b1;
      flsm_pkg::OP_MANUAL: begin
        manual_on = it.manual_allowed;
        if (!it.manual_allowed) begin
          leak_ref    = it.pulse_count;
          leak_ref_ms = it.now_ms;
        end
      end
      flsm_pkg::OP_NOTIFY: res.trip_raised = latch_code(it.notify_code);
      default: ;
    endcase
    res.fault_code = (latched_code != flsm_pkg::FaultNone) ? latched_code : up;
    return res;
  endfunction

  // Random gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Next random item: mostly plausible plant events, some pure noise.
  function automatic flsm_pkg::in_item_t next_plant_item(input int unsigned step_max);
    flsm_pkg::in_item_t it;
    int unsigned        r;
    it = '0;
    if ($urandom_range(0, 9) == 0) begin
      it.opcode         = OpW'($urandom_range(0, 7));
      it.pulse_count    = $urandom();
      it.now_ms         = $urandom();
      it.tank_full      = 1'($urandom_range(0, 1));
      it.tank_empty     = 1'($urandom_range(0, 1));
      it.fill_active    = 1'($urandom_range(0, 1));
      it.manual_allowed = 1'($urandom_range(0, 1));
      it.upstream_error = CodeW'($urandom_range(0, 15));
      it.notify_code    = CodeW'($urandom_range(0, 15));
      return it;
    end
    if ($urandom_range(0, 49) == 0) plant_ms += $urandom();
    else plant_ms += $urandom_range(0, step_max);
    if (plant_filling) begin
      if ($urandom_range(0, 3) != 0) plant_pulses += $urandom_range(1, 20);
    end else if ($urandom_range(0, 9) == 0) begin
      plant_pulses += $urandom_range(1, 8);
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.opcode     = flsm_pkg::OP_STATE;
      plant_filling = 1'($urandom_range(0, 1));
    end else if (r < 16) begin
      it.opcode = flsm_pkg::OP_CLEAR;
    end else if (r < 21) begin
      it.opcode = flsm_pkg::OP_MANUAL;
    end else if (r < 25) begin
      it.opcode = flsm_pkg::OP_NOTIFY;
    end else if (r < 27) begin
      it.opcode = OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
    end else begin
      it.opcode = flsm_pkg::OP_TICK;
    end
    it.pulse_count    = plant_pulses;
    it.now_ms         = plant_ms;
    it.fill_active    = plant_filling;
    it.tank_full      = ($urandom_range(0, 29) == 0);
    it.tank_empty     = 1'($urandom_range(0, 1));
    it.manual_allowed = 1'($urandom_range(0, 1));
    it.upstream_error = ($urandom_range(0, 9) == 0) ? CodeW'($urandom_range(1, 15))
                                                    : flsm_pkg::FaultNone;
    it.notify_code    = CodeW'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic add_row(input logic [OpW-1:0] op, input logic [CountW-1:0] pulses,
                         input logic [CountW-1:0] now, input bit full, input bit empty,
                         input bit fill, input bit allow, input logic [CodeW-1:0] up,
                         input logic [CodeW-1:0] notify, input bit typed,
                         input logic [CodeW-1:0] code, input bit trip, input bit clr);
    stim_row_t row;
    row.item.opcode         = op;
    row.item.pulse_count    = pulses;
    row.item.now_ms         = now;
    row.item.tank_full      = full;
    row.item.tank_empty     = empty;
    row.item.fill_active    = fill;
    row.item.manual_allowed = allow;
    row.item.upstream_error = up;
    row.item.notify_code    = notify;
    row.typed               = typed;
    row.status.fault_code   = code;
    row.status.trip_raised  = trip;
    row.status.cleared      = clr;
    directed_rows.push_back(row);
  endtask

  // Offers one item after a random gap, or with no gap in every fourth run of 40 items, and waits for its transfer.
  task automatic send_item(input flsm_pkg::in_item_t it, input bit typed,
                           input flsm_pkg::out_item_t status, input int unsigned seq);
    int unsigned gap;
    gap = (((seq / 40) % 4) == 1) ? 0 : pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    row_typed    <= typed;
    row_status   <= status;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // Stops offering items and waits until every expected status has arrived.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [CfgW-1:0] vals [4]);
    flsm_pkg::cfg_write_t wr;
    for (int i = 0; i < 4; i++) begin
      wr.index = flsm_pkg::cfg_reg_e'(i);
      wr.data  = vals[i];
      cfg_bus.valid <= 1'b1;
      cfg_bus.data  <= wr;
      do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic flag_error(input string what, input flsm_pkg::out_item_t want,
                            input flsm_pkg::out_item_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected code %0d trip %0b cleared %0b, %s %0d trip %0b cleared %0b",
               $realtime, what, want.fault_code, want.trip_raised, want.cleared,
               "got code", got.fault_code, got.trip_raised, got.cleared);
    end
  endtask

  // Transfer monitor: mirrors limit writes, predicts accepted items, checks results.
  always @(posedge clk) begin
    flsm_pkg::out_item_t want;
    flsm_pkg::out_item_t got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        unique case (cfg_bus.data.index)
          flsm_pkg::CFG_STALL_TIMEOUT:  stall_lim_s  = cfg_bus.data.data;
          flsm_pkg::CFG_LEAK_GRACE:     grace_lim_s  = cfg_bus.data.data;
          flsm_pkg::CFG_LEAK_REBASE:    rebase_lim_s = cfg_bus.data.data;
          flsm_pkg::CFG_LEAK_TOLERANCE: leak_tol     = cfg_bus.data.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        want = predict_status(in_bus.data);
        if (row_typed) want = row_status;
        status_due.push_back(want);
        inputs_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.data;
        if (status_due.size() == 0) begin
          flag_error("status with no item pending", '0, got);
        end else begin
          want = status_due.pop_front();
          if (got.fault_code !== want.fault_code || got.trip_raised !== want.trip_raised ||
              got.cleared !== want.cleared) begin
            flag_error("status mismatch", want, got);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off.
  initial begin
    int unsigned gap;
    int unsigned high_len;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && inputs_taken >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end
      gap = pick_gap();
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      high_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      out_bus.ready <= 1'b1;
      repeat (high_len) @(posedge clk);
    end
  end

  // Main sequence: reset, directed table, then random phases over several limit sets.
  initial begin
    int unsigned     seq;
    logic [CfgW-1:0] lims [4];
    int unsigned     step_max;
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;
    row_typed     <= 1'b0;
    row_status    <= '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state, code extremes, unknown opcodes and notifications.
    add_row(flsm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultMax, 0, 1,
            flsm_pkg::FaultMax, 0, 0);
    add_row(flsm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 4'd15, 0, 1, flsm_pkg::FaultNone, 0, 0);
    add_row(OpUnusedHi, 0, 0, 0, 0, 0, 0, 4'd3, 0, 1, 4'd3, 0, 0);
    add_row(OpUnusedLo, 0, 0, 0, 0, 0, 0, 4'd10, 0, 1, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_NOTIFY, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 1,
            flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_NOTIFY, 0, 0, 0, 0, 0, 0, 0, 4'd15, 1, flsm_pkg::FaultNone, 0, 0);
    // Both floats, then a notification that must not replace the latched code.
    add_row(flsm_pkg::OP_TICK, 0, 0, 1, 1, 0, 0, 0, 0, 1, flsm_pkg::FaultSensor, 1, 0);
    add_row(flsm_pkg::OP_NOTIFY, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultMax, 1,
            flsm_pkg::FaultSensor, 0, 0);
    // Clear is taken on the next tick, which then trips on the top float.
    add_row(flsm_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, flsm_pkg::FaultSensor, 0, 0);
    add_row(flsm_pkg::OP_TICK, 0, 100, 1, 0, 0, 0, 0, 0, 1, flsm_pkg::FaultTopFloat, 1, 1);
    // Clear on a tick with an upstream error: checks stop after the clear.
    add_row(flsm_pkg::OP_CLEAR, 0, 100, 0, 0, 0, 0, 0, 0, 1, flsm_pkg::FaultTopFloat, 0, 0);
    add_row(flsm_pkg::OP_TICK, 0, 100, 1, 0, 0, 0, 4'd7, 0, 1, 4'd7, 0, 1);
    add_row(flsm_pkg::OP_NOTIFY, 0, 100, 0, 0, 0, 0, 0, flsm_pkg::FaultMax, 1,
            flsm_pkg::FaultMax, 1, 0);
    add_row(flsm_pkg::OP_CLEAR, 0, 100, 0, 0, 0, 0, 0, 0, 1, flsm_pkg::FaultMax, 0, 0);
    // Stall timeout while filling.
    add_row(flsm_pkg::OP_TICK, 100, 1000, 0, 0, 1, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, 100, 31001, 0, 0, 1, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    // Leak past the grace window with the valve closed.
    add_row(flsm_pkg::OP_CLEAR, 100, 31001, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, 100, 40000, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, 106, 45001, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    // Manual override suppresses the leak check; releasing it rebaselines.
    add_row(flsm_pkg::OP_CLEAR, 106, 45001, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_MANUAL, 106, 45001, 0, 0, 0, 1, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, '1, '1, 0, 0, 0, 1, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_MANUAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, 0, 3600001, 0, 0, 0, 0, 0, 0, 0, flsm_pkg::FaultNone, 0, 0);
    // Stall clock across a time wrap.
    add_row(flsm_pkg::OP_STATE, 7, 32'hFFFF_FF00, 0, 0, 1, 0, 0, 0, 0,
            flsm_pkg::FaultNone, 0, 0);
    add_row(flsm_pkg::OP_TICK, 7, 32'h0000_7000, 0, 1, 1, 0, 0, 0, 0,
            flsm_pkg::FaultNone, 0, 0);

    seq = 0;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].status, seq);
      seq++;
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      unique case (p)
        0: begin
          lims = '{flsm_pkg::StallTimeoutRst, flsm_pkg::LeakGraceRst,
                   flsm_pkg::LeakRebaseRst, flsm_pkg::LeakToleranceRst};
          step_max = 4000;
        end
        1: begin
          lims = '{16'd0, 16'd0, 16'd0, 16'd0};
          step_max = 3;
        end
        2: begin
          lims = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          step_max = 1000000;
        end
        3: begin
          lims = '{16'd2, 16'd1, 16'd10, 16'd3};
          step_max = 1500;
        end
        default: begin
          lims[0] = CfgW'($urandom_range(0, 20));
          lims[1] = CfgW'($urandom_range(0, 5));
          lims[2] = CfgW'($urandom_range(0, 30));
          lims[3] = CfgW'($urandom_range(0, 10));
          step_max = 2000;
        end
      endcase
      set_limits(lims);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        send_item(next_plant_item(step_max), 1'b0, '0, seq);
        seq++;
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && status_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
